// File: sv/pli_pkg.sv
`default_nettype none

package pli_pkg;

    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 4;
    localparam int POINTS_W   = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int PROD_W     = 2 * VALUE_W;
    localparam int DIV_CNT_W  = 6;
    localparam int SUM_W      = VALUE_W + 4;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [0:0]                t_opcode;
    typedef logic [INDEX_W-1:0]        t_index;
    typedef logic [POINTS_W-1:0]       t_points;
    typedef logic [APB_ADDR_W-3:0]     t_reg_idx;

    localparam t_opcode OP_LOAD  = 1'b0;
    localparam t_opcode OP_QUERY = 1'b1;

    localparam t_reg_idx REG_POINTS = 1'b0;

    localparam t_points POINTS_RESET = 5'd2;

    // quotient cap; anything at or above it saturates the same way
    localparam logic [VALUE_W+1:0] QUO_CAP = {2'b10, {VALUE_W{1'b0}}};

    localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

endpackage

`default_nettype wire

// File: sv/pli_if.sv
`default_nettype none

interface pli_in_if;
    logic              valid;
    logic              ready;
    pli_pkg::t_opcode  opcode;
    pli_pkg::t_index   entry_index;
    pli_pkg::t_value   x_value;
    pli_pkg::t_value   y_value;

    modport source (output valid, output opcode, output entry_index, output x_value,
                    output y_value, input ready);
    modport sink   (input valid, input opcode, input entry_index, input x_value,
                    input y_value, output ready);
endinterface

interface pli_out_if;
    logic              valid;
    logic              ready;
    pli_pkg::t_value   result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);
endinterface

`default_nettype wire

// File: sv/pli_cfg.sv
`default_nettype none

module pli_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pli_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [pli_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [pli_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output pli_pkg::t_points                        o_points_in_use
);

    pli_pkg::t_points  r_points;
    pli_pkg::t_reg_idx reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[pli_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= pli_pkg::POINTS_RESET;
        end else if (wr_en && reg_idx == pli_pkg::REG_POINTS) begin
            r_points <= pwdata[pli_pkg::POINTS_W-1:0];
        end
    end

    always_comb begin
        case (reg_idx)
            pli_pkg::REG_POINTS: begin
                prdata = {{(pli_pkg::APB_DATA_W-pli_pkg::POINTS_W){1'b0}}, r_points};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_points_in_use = r_points;

endmodule

`default_nettype wire

// File: sv/pli_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module pli_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [pli_pkg::PROD_W-1:0]      i_dividend,
    input  wire logic [pli_pkg::VALUE_W-1:0]     i_divisor,
    output logic                                 o_done,
    output logic      [pli_pkg::PROD_W-1:0]      o_quotient
);

    logic                             r_busy;
    logic                             r_done;
    logic [pli_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [pli_pkg::VALUE_W-1:0]      r_rem;
    logic [pli_pkg::PROD_W-1:0]       r_quo;

    logic [pli_pkg::VALUE_W:0]        cur;
    logic [pli_pkg::VALUE_W:0]        diff;
    logic                             ge;
    logic [pli_pkg::VALUE_W-1:0]      n_rem;
    logic [pli_pkg::PROD_W-1:0]       n_quo;

    always_comb begin
        cur   = {r_rem, r_quo[pli_pkg::PROD_W-1]};
        diff  = cur - {1'b0, i_divisor};
        ge    = !diff[pli_pkg::VALUE_W];
        n_rem = ge ? diff[pli_pkg::VALUE_W-1:0] : cur[pli_pkg::VALUE_W-1:0];
        n_quo = {r_quo[pli_pkg::PROD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + pli_pkg::DIV_CNT_W'(1);
                if (&r_cnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: sv/piecewise_linear_interpolator.sv
`default_nettype none

// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    opcode, entry_index, x_value, y_value
// o_out     out  valid/ready    result_value
// APB       in   psel/penable   paddr, pwdata -> prdata (points_in_use at 0x0)
//
// Load transaction: table written at the accept edge.
// Query transaction: o_out.valid follows a scan of the n points in use, one entry per
// cycle, and then a serial divide; clamps skip the divide.
// Synchronous active-low reset; points_in_use resets to 2, table is unset.
// i_in.ready is high only while idle; a finished result waits in the output
// register, and the next transaction is taken while it is still pending.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    pli_in_if.sink                               i_in,
    pli_out_if.source                            o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pli_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [pli_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [pli_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int IW = $clog2(MAX_POINTS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LAST  = 9'b000000010,
        S_FIRST = 9'b000000100,
        S_SCAN  = 9'b000001000,
        S_ABS   = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_SUM   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state                           r_state, n_state;
    logic                             r_out_valid, n_out_valid;
    pli_pkg::t_value                  r_out_val;

    pli_pkg::t_value                  r_x_mem [MAX_POINTS];
    pli_pkg::t_value                  r_y_mem [MAX_POINTS];
    pli_pkg::t_value                  r_xr, r_yr;

    logic [IW-1:0]                    r_addr, r_idx, r_last;
    pli_pkg::t_value                  r_q, r_xlast, r_xp, r_yp, r_y0, r_res;
    logic                             r_asc, r_neg, r_div_start;
    logic signed [pli_pkg::VALUE_W:0] r_dy, r_t, r_dx;
    logic [pli_pkg::VALUE_W-1:0]      r_ma, r_mb, r_md;
    logic [pli_pkg::PROD_W-1:0]       r_prod;

    pli_pkg::t_points                 points;
    logic                             div_done;
    logic [pli_pkg::PROD_W-1:0]       quo;

    logic                             in_fire, load_wr;
    logic [31:0]                      idx_ext, pu_ext, last_ext;
    logic                             asc_now, hit, at_last;
    logic signed [pli_pkg::VALUE_W:0] dy_w, t_w, dx_w;
    logic [pli_pkg::VALUE_W:0]        ma_w, mb_w, md_w;
    logic [pli_pkg::VALUE_W+1:0]      quo_cap;
    logic signed [pli_pkg::SUM_W-1:0] y0_e, q_e, sum_w, sat_w;
    logic                             slot_free;

    pli_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_points_in_use (points)
    );

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_md),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign in_fire            = i_in.valid && i_in.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_val;
    assign slot_free          = !r_out_valid || o_out.ready;

    always_comb begin
        idx_ext  = 32'(i_in.entry_index);
        load_wr  = in_fire && (i_in.opcode == pli_pkg::OP_LOAD) &&
                   (idx_ext < 32'(MAX_POINTS));
        pu_ext   = 32'(points);
        if (pu_ext == 32'd0) begin
            last_ext = 32'd0;
        end else if (pu_ext > 32'(MAX_POINTS)) begin
            last_ext = 32'(MAX_POINTS - 1);
        end else begin
            last_ext = pu_ext - 32'd1;
        end
    end

    // table memories, one read port each
    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_x_mem[idx_ext[IW-1:0]] <= i_in.x_value;
            r_y_mem[idx_ext[IW-1:0]] <= i_in.y_value;
        end
        r_xr <= r_x_mem[r_addr];
        r_yr <= r_y_mem[r_addr];
    end

    always_comb begin
        asc_now = (r_idx == '0) ? (r_xr < r_xlast) : r_asc;
        hit     = asc_now ? (r_q <= r_xr) : (r_q >= r_xr);
        at_last = (r_idx == r_last);
        dy_w    = {r_yr[pli_pkg::VALUE_W-1], r_yr} - {r_yp[pli_pkg::VALUE_W-1], r_yp};
        t_w     = {r_q[pli_pkg::VALUE_W-1], r_q} - {r_xp[pli_pkg::VALUE_W-1], r_xp};
        dx_w    = {r_xr[pli_pkg::VALUE_W-1], r_xr} - {r_xp[pli_pkg::VALUE_W-1], r_xp};
        ma_w    = r_dy[pli_pkg::VALUE_W] ? -r_dy : r_dy;
        mb_w    = r_t[pli_pkg::VALUE_W]  ? -r_t  : r_t;
        md_w    = r_dx[pli_pkg::VALUE_W] ? -r_dx : r_dx;
        quo_cap = (|quo[pli_pkg::PROD_W-1:pli_pkg::VALUE_W+1]) ? pli_pkg::QUO_CAP
                                                               : quo[pli_pkg::VALUE_W+1:0];
        y0_e    = {{(pli_pkg::SUM_W-pli_pkg::VALUE_W){r_y0[pli_pkg::VALUE_W-1]}}, r_y0};
        q_e     = {{(pli_pkg::SUM_W-pli_pkg::VALUE_W-2){1'b0}}, quo_cap};
        sum_w   = r_neg ? (y0_e - q_e) : (y0_e + q_e);
        if (sum_w > pli_pkg::SAT_HI) begin
            sat_w = pli_pkg::SAT_HI;
        end else if (sum_w < pli_pkg::SAT_LO) begin
            sat_w = pli_pkg::SAT_LO;
        end else begin
            sat_w = sum_w;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_in.opcode == pli_pkg::OP_QUERY) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_FIRST;
            end
            S_FIRST: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (hit) begin
                    n_state = (r_idx == '0) ? S_DONE : S_ABS;
                end else if (at_last) begin
                    n_state = S_DONE;
                end
            end
            S_ABS: begin
                n_state = (md_w == '0) ? S_DONE : S_MUL;
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_div_start <= (r_state == S_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr <= last_ext[IW-1:0];
                r_last <= last_ext[IW-1:0];
                r_q    <= i_in.x_value;
            end
            S_LAST: begin
                r_addr <= '0;
            end
            S_FIRST: begin
                r_xlast <= r_xr;
                r_addr  <= r_addr + IW'(1);
                r_idx   <= '0;
            end
            S_SCAN: begin
                r_addr <= r_addr + IW'(1);
                if (r_idx == '0) begin
                    r_asc <= asc_now;
                end
                if (hit) begin
                    r_res <= r_yr;
                    r_y0  <= r_yp;
                    r_dy  <= dy_w;
                    r_t   <= t_w;
                    r_dx  <= dx_w;
                end else if (at_last) begin
                    r_res <= r_yr;
                end else begin
                    r_xp  <= r_xr;
                    r_yp  <= r_yr;
                    r_idx <= r_idx + IW'(1);
                end
            end
            S_ABS: begin
                r_res <= r_y0;
                r_ma  <= ma_w[pli_pkg::VALUE_W-1:0];
                r_mb  <= mb_w[pli_pkg::VALUE_W-1:0];
                r_md  <= md_w[pli_pkg::VALUE_W-1:0];
                r_neg <= r_dy[pli_pkg::VALUE_W] ^ r_t[pli_pkg::VALUE_W] ^ r_dx[pli_pkg::VALUE_W];
            end
            S_MUL: begin
                r_prod <= r_ma * r_mb;
            end
            S_SUM: begin
                r_res <= sat_w[pli_pkg::VALUE_W-1:0];
            end
            S_DONE: begin
                if (slot_free) begin
                    r_out_val <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: tb/piecewise_linear_interpolator_tb.sv
`default_nettype none

module piecewise_linear_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS   = 16;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 100;
    localparam int PHASE_ITEMS  = 110;
    localparam int NUM_PHASES   = 10;
    localparam int NUM_DIRECTED = 23;

    typedef struct packed {
        pli_pkg::t_opcode op;
        pli_pkg::t_index  idx;
        pli_pkg::t_value  x;
        pli_pkg::t_value  y;
        logic             typed;
        pli_pkg::t_value  want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [pli_pkg::APB_ADDR_W-1:0] paddr;
    logic [pli_pkg::APB_DATA_W-1:0] pwdata;
    logic [pli_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    pli_in_if  in_ch();
    pli_out_if out_ch();

    piecewise_linear_interpolator #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // breakpoint table and point count as the block should hold them
    pli_pkg::t_value  bp_x [MAX_POINTS];
    pli_pkg::t_value  bp_y [MAX_POINTS];
    pli_pkg::t_points n_points = pli_pkg::POINTS_RESET;

    pli_pkg::t_value pending_results[$];

    int errors      = 0;
    int n_loads     = 0;
    int n_queries   = 0;
    int n_results   = 0;
    int n_settings  = 0;
    int n_holds     = 0;
    int snd_idle    = 0;
    int rcv_stall   = 0;
    int quiet_cycles = 0;
    logic hold_req;

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{pli_pkg::OP_LOAD,  4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{pli_pkg::OP_LOAD,  4'd1,  32'h0001_0000, 32'h0002_0000, 1'b0, 32'h0},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h8000_0000, 32'h1234_5678, 1'b1, 32'h0000_0000},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0002_0000},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h0000_8000, 32'h0000_0000, 1'b0, 32'h0},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // full-scale segment
        '{pli_pkg::OP_LOAD,  4'd0,  32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0},
        '{pli_pkg::OP_LOAD,  4'd1,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
        '{pli_pkg::OP_QUERY, 4'd0,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0},
        // descending table
        '{pli_pkg::OP_LOAD,  4'd0,  32'h0005_0000, 32'hFFFF_0000, 1'b0, 32'h0},
        '{pli_pkg::OP_LOAD,  4'd1,  32'hFFFB_0000, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h0006_0000, 32'h0000_0000, 1'b1, 32'hFFFF_0000},
        '{pli_pkg::OP_QUERY, 4'd0,  32'hFFFA_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h0001_2345, 32'h0000_0000, 1'b0, 32'h0},
        // equal end points: taken as descending
        '{pli_pkg::OP_LOAD,  4'd0,  32'h0003_0000, 32'h0000_0005, 1'b0, 32'h0},
        '{pli_pkg::OP_LOAD,  4'd1,  32'h0003_0000, 32'h0000_0009, 1'b0, 32'h0},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h0003_0000, 32'h0000_0000, 1'b1, 32'h0000_0005},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h0002_0000, 32'h0000_0000, 1'b1, 32'h0000_0009},
        '{pli_pkg::OP_QUERY, 4'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0005},
        '{pli_pkg::OP_LOAD,  4'd15, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 32'h0}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int active_points();
        if (n_points == 0) return 1;
        if (n_points > MAX_POINTS) return MAX_POINTS;
        return int'(n_points);
    endfunction

    function automatic pli_pkg::t_value interp_value(pli_pkg::t_value q);
        int n;
        bit asc;
        bit found;
        longint y0, dy, t, dx, r;
        bit [63:0] m_dy, m_t, m_dx, quo;
        bit neg;
        n = active_points();
        asc = bp_x[0] < bp_x[n-1];
        found = 1'b0;
        r = longint'(bp_y[n-1]);
        for (int i = 0; i < n; i++) begin
            if (!found && (asc ? (q <= bp_x[i]) : (q >= bp_x[i]))) begin
                found = 1'b1;
                if (i == 0) begin
                    r = longint'(bp_y[0]);
                end else begin
                    y0 = longint'(bp_y[i-1]);
                    dy = longint'(bp_y[i]) - y0;
                    t  = longint'(q) - longint'(bp_x[i-1]);
                    dx = longint'(bp_x[i]) - longint'(bp_x[i-1]);
                    if (dx == 0) begin
                        r = y0;
                    end else begin
                        m_dy = (dy < 0) ? -dy : dy;
                        m_t  = (t < 0) ? -t : t;
                        m_dx = (dx < 0) ? -dx : dx;
                        quo  = (m_dy * m_t) / m_dx;
                        neg  = ((dy < 0) != (t < 0)) != (dx < 0);
                        if (quo > (64'd1 << 40)) quo = 64'd1 << 40;
                        r = neg ? y0 - longint'(quo) : y0 + longint'(quo);
                    end
                end
            end
        end
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return pli_pkg::t_value'(r[31:0]);
    endfunction

    function automatic pli_pkg::t_value pick_query();
        int n, k;
        longint a, b, lo, span;
        n = active_points();
        case ($urandom_range(9))
            0, 1: return pli_pkg::t_value'($urandom);
            2, 3: return bp_x[$urandom_range(n-1)];
            default: begin
                if (n < 2) return bp_x[0] + pli_pkg::t_value'(int'($urandom_range(2)) - 1);
                k = $urandom_range(n-2);
                a = longint'(bp_x[k]);
                b = longint'(bp_x[k+1]);
                lo = (a < b) ? a : b;
                span = ((a < b) ? b - a : a - b) + 1;
                return pli_pkg::t_value'(lo + longint'({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= 10)
            $display("MISMATCH %s: expected %08h, got %08h", what, want, got);
    endtask

    task automatic send_item(pli_pkg::t_opcode op, pli_pkg::t_index idx,
                             pli_pkg::t_value x, pli_pkg::t_value y,
                             logic typed = 1'b0, pli_pkg::t_value want = '0);
        if ($urandom_range(99) < snd_idle) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.entry_index <= idx;
        in_ch.x_value     <= x;
        in_ch.y_value     <= y;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == pli_pkg::OP_LOAD) begin
            bp_x[idx] = x;
            bp_y[idx] = y;
            n_loads++;
        end else begin
            pending_results.push_back(typed ? want : interp_value(x));
            n_queries++;
        end
    endtask

    task automatic set_points(logic [31:0] value);
        logic [31:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {pli_pkg::REG_POINTS, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        n_points = value[pli_pkg::POINTS_W-1:0];
        n_settings++;
        // read back: this edge is the setup of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== 32'(n_points)) report_mismatch("points_in_use readback", 32'(n_points), rd);
    endtask

    task automatic load_table();
        pli_pkg::t_value xs[$];
        pli_pkg::t_value ys[$];
        int order[$];
        bit wide_x, wide_y;
        int k;
        wide_x = $urandom_range(1);
        wide_y = $urandom_range(1);
        for (int i = 0; i < MAX_POINTS; i++) begin
            xs.push_back(wide_x ? pli_pkg::t_value'($urandom)
                                : pli_pkg::t_value'($urandom_range(32'h00A0_0000))
                                  - 32'sh0050_0000);
            ys.push_back(wide_y ? pli_pkg::t_value'($urandom)
                                : pli_pkg::t_value'($urandom_range(32'h00A0_0000))
                                  - 32'sh0050_0000);
            order.push_back(i);
        end
        xs.sort();
        if ($urandom_range(3) == 0) begin
            k = $urandom_range(1, MAX_POINTS - 1);
            xs[k] = xs[k-1];
        end
        if ($urandom_range(1)) xs.reverse();
        order.shuffle();
        foreach (order[i])
            send_item(pli_pkg::OP_LOAD, pli_pkg::t_index'(order[i]), xs[order[i]],
                      ys[order[i]]);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        pli_pkg::t_value want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no query pending", 32'h0, out_ch.result_value);
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (out_ch.result_value !== want)
                    report_mismatch("result_value", want, out_ch.result_value);
            end
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_stall);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int pts_list [NUM_PHASES];
        int snd_modes [4];
        int rcv_modes [4];
        int pts;

        pts_list  = '{16, 1, 8, 0, 31, 5, 17, 2, 0, 16};
        snd_modes = '{0, 85, 0, 13};
        rcv_modes = '{0, 0, 85, 13};

        i_rst_n           <= 1'b0;
        hold_req          <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= pli_pkg::OP_LOAD;
        in_ch.entry_index <= '0;
        in_ch.x_value     <= '0;
        in_ch.y_value     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset point count of 2 is relied on here
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].x,
                      directed_rows[i].y, directed_rows[i].typed, directed_rows[i].want);

        for (int p = 0; p < NUM_PHASES; p++) begin
            in_ch.valid <= 1'b0;
            wait_drained();
            pts = (p == 8) ? int'($urandom_range(3, 15)) : pts_list[p];
            set_points(32'(pts));
            snd_idle  = snd_modes[p % 4];
            rcv_stall = rcv_modes[p % 4];
            load_table();
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (j == PHASE_ITEMS / 2) load_table();
                if (p == 0 && j == 30) begin
                    // long output stall while queries keep coming
                    in_ch.valid <= 1'b0;
                    hold_req    <= 1'b1;
                    @(posedge i_clk);
                    hold_req <= 1'b0;
                    n_holds++;
                    for (int h = 0; h < 12; h++)
                        send_item(pli_pkg::OP_QUERY, pli_pkg::t_index'($urandom), pick_query(),
                                  pli_pkg::t_value'($urandom));
                end
                if ($urandom_range(99) < 8)
                    send_item(pli_pkg::OP_LOAD, pli_pkg::t_index'($urandom_range(15)),
                              pli_pkg::t_value'($urandom), pli_pkg::t_value'($urandom));
                else
                    send_item(pli_pkg::OP_QUERY, pli_pkg::t_index'($urandom), pick_query(),
                              pli_pkg::t_value'($urandom));
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();

        $display("Run covered %0d loads and %0d queries, %0d results compared,",
                 n_loads, n_queries, n_results);
        $display("%0d point-count settings, %0d long output hold-off(s), %0d mismatches.",
                 n_settings, n_holds, errors);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
